// ===== sv/tcle_pkg.sv =====
// Package for the text cursor layout engine.
// Holds field widths, layout constants, command and register codes and the result types.
// No dependencies.
`default_nettype none

package tcle_pkg;

  localparam int LINE_PIXELS  = 800;
  localparam int LAST_ROW     = 29;
  localparam int NARROW_WIDTH = 8;

  localparam int PX_W      = 10;
  localparam int GH_W      = 5;
  localparam int LIM_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int RES_DEPTH = 4;

  localparam logic [1:0] KIND_NARROW = 2'd0;
  localparam logic [1:0] KIND_WIDE   = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDE_WIDTH   = 2'd1;

  localparam logic [7:0] BYTE_SPACE    = 8'h20;
  localparam logic [7:0] BYTE_TILDE    = 8'h7e;
  localparam logic [7:0] BYTE_NEWLINE  = 8'h0a;
  localparam logic [7:0] BYTE_WIDE_MIN = 8'ha1;

  typedef struct packed {
    logic [1:0]      kind;
    logic [15:0]     code;
    logic [PX_W-1:0] row;
    logic [PX_W-1:0] col;
    logic            last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

`default_nettype wire

// ===== sv/tcle_core.sv =====
// Cursor, lead byte and stop state with the per-byte layout decision.
// Produces up to two results per accepted transaction; uses tcle_pkg.
`default_nettype none

module tcle_core import tcle_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 take,
  input  wire logic                 op,
  input  wire logic [7:0]           text_byte,
  input  wire logic                 string_start,
  input  wire logic [4:0]           row_number,
  input  wire logic [6:0]           column_number,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [GH_W-1:0]      cfg_wdata,
  output push_t                     push
);

  localparam logic [PX_W-1:0] AT_END = PX_W'(LINE_PIXELS - NARROW_WIDTH);

  logic [GH_W-1:0]  gh_r, ww_r;
  logic [LIM_W-1:0] lim_r;
  logic [PX_W-1:0]  line_r, line_nxt, along_r, along_nxt;
  logic [7:0]       lead_r, lead_nxt;
  logic             pend_r, pend_nxt, stopped_r, stopped_nxt;

  logic             pend_e, stop_e, emit, nl, pre_clr, post_clr;
  logic [1:0]       gl_kind;
  logic [15:0]      gl_code;
  logic [GH_W-1:0]  step;
  logic [PX_W-1:0]  line1, along1;
  logic [PX_W:0]    sum;
  result_t          glyph_res, clear_res;

  always_comb begin
    line_nxt    = line_r;
    along_nxt   = along_r;
    lead_nxt    = lead_r;
    pend_nxt    = pend_r;
    stopped_nxt = stopped_r;
    pend_e      = pend_r & ~string_start;
    stop_e      = stopped_r & ~string_start;
    emit        = 1'b0;
    nl          = 1'b0;
    pre_clr     = 1'b0;
    post_clr    = 1'b0;
    gl_kind     = KIND_NARROW;
    gl_code     = '0;
    step        = GH_W'(NARROW_WIDTH);
    line1       = line_r;
    along1      = along_r;
    sum         = '0;
    if (op) begin
      line_nxt  = {1'b0, row_number, 4'b0000};
      along_nxt = {column_number, 3'b000};
      pend_nxt  = 1'b0;
    end else begin
      pend_nxt    = pend_e;
      stopped_nxt = stop_e;
      if (!stop_e) begin
        if (pend_e) begin
          pend_nxt = 1'b0;
          if (text_byte >= BYTE_WIDE_MIN) begin
            emit    = 1'b1;
            gl_kind = KIND_WIDE;
            gl_code = {text_byte, lead_r};
            step    = ww_r;
            if (along_r == AT_END) begin
              along1  = '0;
              pre_clr = (LIM_W'(line_r) == lim_r);
              line1   = pre_clr ? '0 : line_r + PX_W'(gh_r);
            end
          end else begin
            stopped_nxt = 1'b1;
          end
        end else if (text_byte >= BYTE_SPACE && text_byte <= BYTE_TILDE) begin
          emit    = 1'b1;
          gl_kind = KIND_NARROW;
          gl_code = {8'h00, text_byte - BYTE_SPACE};
        end else if (text_byte == BYTE_NEWLINE) begin
          nl          = 1'b1;
          stopped_nxt = 1'b1;
        end else if (text_byte >= BYTE_WIDE_MIN) begin
          lead_nxt = text_byte;
          pend_nxt = 1'b1;
        end else begin
          stopped_nxt = 1'b1;
        end
      end
      if (emit) begin
        sum = {1'b0, along1} + (PX_W + 1)'(step);
        if (sum >= (PX_W + 1)'(LINE_PIXELS)) begin
          along_nxt = '0;
          post_clr  = (LIM_W'(line1) == lim_r);
          line_nxt  = post_clr ? '0 : line1 + PX_W'(gh_r);
        end else begin
          along_nxt = sum[PX_W-1:0];
          line_nxt  = line1;
        end
      end
      if (nl) begin
        along_nxt = '0;
        post_clr  = (LIM_W'(line_r) == lim_r);
        line_nxt  = post_clr ? '0 : line_r + PX_W'(gh_r);
      end
    end
  end

  always_comb begin
    glyph_res      = '{kind: gl_kind, code: gl_code, row: line1, col: along1, last: 1'b0};
    clear_res      = '{kind: KIND_CLEAR, code: '0, row: '0, col: '0, last: 1'b0};
    push.count     = 2'd0;
    push.first     = clear_res;
    push.second    = clear_res;
    if (emit) begin
      if (pre_clr) begin
        push.count  = 2'd2;
        push.first  = clear_res;
        push.second = glyph_res;
      end else begin
        push.first  = glyph_res;
        push.count  = post_clr ? 2'd2 : 2'd1;
      end
    end else if (post_clr) begin
      push.count = 2'd1;
    end
    if (push.count == 2'd2) begin
      push.second.last = 1'b1;
    end else begin
      push.first.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gh_r      <= GH_W'(16);
      ww_r      <= GH_W'(16);
      lim_r     <= LIM_W'(LAST_ROW * 16);
      line_r    <= '0;
      along_r   <= '0;
      lead_r    <= '0;
      pend_r    <= 1'b0;
      stopped_r <= 1'b0;
    end else begin
      if (take) begin
        line_r    <= line_nxt;
        along_r   <= along_nxt;
        lead_r    <= lead_nxt;
        pend_r    <= pend_nxt;
        stopped_r <= stopped_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_GLYPH_HEIGHT: begin
            gh_r  <= cfg_wdata;
            lim_r <= LIM_W'(LAST_ROW) * LIM_W'(cfg_wdata);
          end
          CFG_WIDE_WIDTH: begin
            ww_r <= cfg_wdata;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // A wrap before a wide glyph leaves the cursor at the line start, so the
  // advance after it can never wrap again.
  a_one_clear: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> !(pre_clr && post_clr))
    else $error("two clear-screen results for one transaction");

  a_stopped_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !op && stopped_r && !string_start && !cfg_we)
      |=> ($stable(line_r) && $stable(along_r) && stopped_r))
    else $error("stopped string changed the cursor");

endmodule

`default_nettype wire

// ===== sv/tcle_rfifo.sv =====
// Result queue: takes up to two results per cycle, hands out one per cycle while out_ready is high.
// Uses the result types of tcle_pkg.
`default_nettype none

module tcle_rfifo import tcle_pkg::*; #(
  parameter int DEPTH = RES_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push_en,
  input  wire push_t push,
  output logic       room,
  output logic       out_valid,
  input  wire logic  out_ready,
  output result_t    head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  result_t         mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr1, wr2;
  logic [CW-1:0]   count_r, count_nxt;
  logic [1:0]      n_push;
  logic            pop;

  function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    n_push     = push_en ? push.count : 2'd0;
    pop        = out_valid & out_ready;
    wr1        = next_ptr(wr_ptr_r);
    wr2        = next_ptr(wr1);
    wr_ptr_nxt = (n_push == 2'd2) ? wr2 : ((n_push == 2'd1) ? wr1 : wr_ptr_r);
    rd_ptr_nxt = pop ? next_ptr(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CW'(n_push) - CW'(pop);
  end

  assign room      = (count_r <= CW'(DEPTH - 2));
  assign out_valid = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem_r[wr_ptr_r] <= push.first;
    end
    if (n_push == 2'd2) begin
      mem_r[wr1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("result queue overflow");

  a_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 && n_push == 2'd0) |=> !out_valid)
    else $error("result appeared without a push");

endmodule

`default_nettype wire

// ===== sv/text_cursor_layout_engine_top.sv =====
// Top level of the text cursor layout engine: layout core and result queue.
// Depends on tcle_pkg, tcle_core and tcle_rfifo.
//
// One input transaction is taken every clock cycle while the result queue
// has room. The layout core decides each byte in the cycle it is accepted
// and writes zero, one or two results (glyph draw and clear screen) into a
// small result queue, which hands out one result per cycle while the output
// is ready. The first result of a byte is offered on the output in the cycle
// after the byte is accepted when the queue is empty. The two results of a
// byte leave in turn; the input stays ready as long as the queue has room for
// two results, so with the default depth of four and a ready output a steady
// stream of one-result bytes runs at one transaction per cycle in both directions.
// Configuration writes are always ready and take effect on the next byte.
`default_nettype none

module text_cursor_layout_engine_top import tcle_pkg::*; #(
  parameter int RES_Q_DEPTH = RES_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_op,
  input  wire logic [7:0]           in_text_byte,
  input  wire logic                 in_string_start,
  input  wire logic [4:0]           in_row_number,
  input  wire logic [6:0]           in_column_number,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [1:0]                out_command_kind,
  output logic [15:0]               out_glyph_code,
  output logic [PX_W-1:0]           out_pixel_row,
  output logic [PX_W-1:0]           out_pixel_column,
  output logic                      out_last_result,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [GH_W-1:0]      cfg_wdata
);

  logic    take, room;
  push_t   push;
  result_t head;

  assign cfg_ready = 1'b1;
  assign in_ready  = room;
  assign take      = in_valid & room;

  tcle_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .op           (in_op),
    .text_byte    (in_text_byte),
    .string_start (in_string_start),
    .row_number   (in_row_number),
    .column_number(in_column_number),
    .cfg_we       (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .push         (push)
  );

  tcle_rfifo #(
    .DEPTH(RES_Q_DEPTH)
  ) u_rfifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_en  (take),
    .push     (push),
    .room     (room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .head     (head)
  );

  assign out_command_kind = head.kind;
  assign out_glyph_code   = head.code;
  assign out_pixel_row    = head.row;
  assign out_pixel_column = head.col;
  assign out_last_result  = head.last;

endmodule

`default_nettype wire
